// ===== sv/lcsl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the lidar collision speed limiter.
// No dependencies; used by lcsl_root_div, the top level and the testbench.
package lcsl_pkg;

    // Operations of the shared root / divide unit
    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } t_du_op;

    localparam int DU_RES_W = 30;   // quotient width
    localparam int SQ_W     = 34;   // squared distance width

    // Configuration register indexes
    localparam logic [1:0] REG_SAFE_TIME = 2'd0;
    localparam logic [1:0] REG_RADIUS    = 2'd1;
    localparam logic [1:0] REG_STEP      = 2'd2;
    localparam logic [1:0] REG_OFFSET    = 2'd3;

    // Request word into the root / divide unit
    typedef struct packed {
        logic            start;
        t_du_op          op;
        logic [SQ_W-1:0] a;    // radicand or dividend
        logic [16:0]     b;    // divisor
    } t_du_req;

    // Status back from the unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_du_sts;

endpackage

// ===== sv/lcsl_root_div.sv =====
`timescale 1ns / 1ps
// Shared iterative unit: restoring square root (18 steps) and restoring
// divide (30 steps), one subtract-compare a cycle. Uses lcsl_pkg.
module lcsl_root_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcsl_pkg::t_du_req             i_req,
    output lcsl_pkg::t_du_sts             o_sts,
    output logic [lcsl_pkg::DU_RES_W-1:0] o_res
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    lcsl_pkg::t_du_op     r_op, n_op;
    logic [4:0]           r_cnt, n_cnt;
    logic [34:0]          r_rem, n_rem;
    logic [34:0]          r_res, n_res;
    logic [29:0]          r_q, n_q;
    logic [16:0]          r_b, n_b;

    logic [34:0] sq_bit;
    logic [34:0] sq_sum;
    logic [17:0] dv_trial;
    logic [4:0]  last_cnt;

    // Next state of the iteration
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_res  = r_res;
        n_q    = r_q;
        n_b    = r_b;
        sq_bit   = 35'd1 << (6'd34 - {r_cnt, 1'b0});
        sq_sum   = r_res + sq_bit;
        dv_trial = {r_rem[16:0], r_q[29]};
        last_cnt = (r_op == lcsl_pkg::OP_SQRT) ? 5'd17 : 5'd29;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = '0;
            n_b    = i_req.b;
            if (i_req.op == lcsl_pkg::OP_SQRT) begin
                n_rem = {1'b0, i_req.a};
                n_res = '0;
            end else begin
                n_rem = '0;
                n_q   = i_req.a[29:0];
            end
        end else if (r_busy) begin
            if (r_op == lcsl_pkg::OP_SQRT) begin
                if (r_rem >= sq_sum) begin
                    n_rem = r_rem - sq_sum;
                    n_res = (r_res >> 1) + sq_bit;
                end else begin
                    n_res = r_res >> 1;
                end
            end else begin
                n_q = {r_q[28:0], 1'b0};
                if (dv_trial >= {1'b0, r_b}) begin
                    n_rem = 35'(dv_trial - {1'b0, r_b});
                    n_q[0] = 1'b1;
                end else begin
                    n_rem = 35'(dv_trial);
                end
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == last_cnt) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold iteration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= lcsl_pkg::OP_SQRT;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_res <= n_res;
        r_q   <= n_q;
        r_b   <= n_b;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_res      = (r_op == lcsl_pkg::OP_SQRT) ? r_res[29:0] : r_q;

endmodule

// ===== sv/lcsl_cordic.sv =====
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one micro-rotation a cycle over 16 steps, then a
// quadrant fold and scale to whole mm. No package dependencies.
module lcsl_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [30:0]        i_x0,     // range times inverse gain, Q15
    input  logic [31:0]        i_phase,  // 2^32 per turn
    output logic               o_done,
    output logic signed [17:0] o_px,
    output logic signed [17:0] o_py
);

    localparam logic [29:0] ATAN_TURN [16] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861
    };

    // Shift right with truncation toward zero
    function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
                                                  input logic [3:0] sh);
        logic signed [33:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    logic               r_busy, r_fold, r_done;
    logic [3:0]         r_i;
    logic [1:0]         r_quad;
    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic signed [17:0] r_px, r_py;

    logic signed [33:0] dx, dy, fc, fs;

    // Micro-rotation deltas and quadrant fold
    always_comb begin
        dx = shr_tz(r_y, r_i);
        dy = shr_tz(r_x, r_i);
        case (r_quad)
            2'd0:    begin fc = r_x;  fs = r_y;  end
            2'd1:    begin fc = -r_y; fs = r_x;  end
            2'd2:    begin fc = -r_x; fs = -r_y; end
            default: begin fc = r_y;  fs = -r_x; end
        endcase
    end

    // Advance rotation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fold <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            r_fold <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= $signed({3'b0, i_x0});
                r_y    <= '0;
                r_z    <= $signed({3'b0, i_phase[29:0]});
                r_quad <= i_phase[31:30];
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - $signed({3'b0, ATAN_TURN[r_i]});
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + $signed({3'b0, ATAN_TURN[r_i]});
                end
                r_i <= r_i + 4'd1;
                if (r_i == 4'd15) begin
                    r_busy <= 1'b0;
                    r_fold <= 1'b1;
                end
            end else if (r_fold) begin
                r_px   <= 18'(shr_tz(fc, 4'd15));
                r_py   <= 18'(shr_tz(fs, 4'd15));
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_px   = r_px;
    assign o_py   = r_py;

endmodule

// ===== sv/lidar_collision_speed_limiter_top.sv =====
`timescale 1ns / 1ps
// Lidar collision speed limiter: sequencer, shared multiplier, scan state.
// Uses lcsl_pkg, lcsl_cordic and lcsl_root_div.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata range/linear/angular, tlast, tuser kind
//  m_axis    out  m_axis_tvalid/tready    tdata safe_linear/safe_angular/distance
//  cfg       in   i_cfg_valid/o_cfg_ready i_cfg_addr, i_cfg_data
//
// A beam passes through the angle and gain products, the 16-step CORDIC, the
// squares of both coordinates and the compare; the last beam of a scan also runs
// the 18-step root and the 30-step divide on the shared unit.
// A command is compared with the limit, and a clipped one adds a 30-step divide.
// One word is in work at a time; s_axis_tready is high only when idle.
// A finished result waits in the output register; the next word may be taken
// meanwhile, and a new result waits until that register is free.
// Reset is synchronous, active low, and needs no clearing pass.
module lidar_collision_speed_limiter_top #(
    parameter int MAX_BEAMS  = 4096,
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // range_mm, linear_cmd, angular_cmd
    input  logic        s_axis_tlast,   // last_beam
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // safe_linear, safe_angular, nearest_distance_mm, pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_BEAMS);

    typedef enum logic [4:0] {
        S_IDLE, S_ANG, S_GAIN, S_CORD_GO, S_CORD, S_SQX, S_SQY, S_CMP,
        S_ROOT_GO, S_ROOT, S_FREE, S_DIV_GO, S_DIV,
        S_CMD, S_ANGM, S_CDIV_GO, S_CDIV, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_safe_time, r_radius, r_step;
    logic [9:0]  r_offset;

    // input word
    logic        r_last;
    logic [15:0] r_range;
    logic [15:0] r_lin, r_ang;

    // scan and committed state
    logic [CW-1:0]         r_cnt;
    logic [33:0]           r_best;
    logic signed [17:0]    r_bestx, r_besty;
    logic [16:0]           r_nearest;
    logic signed [17:0]    r_ox, r_oy;
    logic [14:0]           r_limit;

    // datapath
    logic [31:0]        r_phase;
    logic signed [17:0] r_bx, r_by;
    logic [33:0]        r_acc;
    logic signed [35:0] r_prod;
    logic [16:0]        r_d;
    logic [15:0]        r_olin, r_oang;

    // output register
    logic        r_ovalid;
    logic [15:0] r_m_lin, r_m_ang;
    logic [16:0] r_m_dist;

    // shared units
    lcsl_pkg::t_du_req du_req;
    lcsl_pkg::t_du_sts du_sts;
    logic [lcsl_pkg::DU_RES_W-1:0] du_res;
    logic              cord_start, cord_done;
    logic signed [17:0] cord_px, cord_py;

    logic signed [17:0] m_a, m_b;
    logic [33:0]  sq;
    logic [16:0]  free_mm;
    logic [15:0]  t_eff;
    logic signed [16:0] lin_x, ang_x;
    logic [16:0]  lin_abs, ang_abs;
    logic signed [18:0] oy_x;
    logic [18:0]  oy_abs;
    logic         in_band, over, stop, fwd, rev, clip;
    logic         load_out;

    // Derived arithmetic terms
    always_comb begin
        sq      = r_acc + r_prod[33:0];
        free_mm = (r_d >= {1'b0, r_radius}) ? (r_d - {1'b0, r_radius})
                                             : ({1'b0, r_radius} - r_d);
        t_eff   = (r_safe_time == '0) ? 16'd1 : r_safe_time;
        lin_x   = $signed({r_lin[15], r_lin});
        ang_x   = $signed({r_ang[15], r_ang});
        lin_abs = (lin_x < 0) ? 17'(-lin_x) : 17'(lin_x);
        ang_abs = (ang_x < 0) ? 17'(-ang_x) : 17'(ang_x);
        oy_x    = $signed({r_oy[17], r_oy});
        oy_abs  = (oy_x < 0) ? 19'(-oy_x) : 19'(oy_x);
        in_band = oy_abs < {3'b0, r_radius};
        over    = lin_abs > {2'b0, r_limit};
        stop    = r_nearest < {1'b0, r_radius};
        fwd     = !r_lin[15] && !r_ox[17];
        rev     = r_lin[15] && (r_ox[17] || (r_ox == '0));
        clip    = in_band && over && (fwd || rev);
        load_out = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);
    end

    // Select multiplier operands
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_ANG: begin
                m_a = $signed({{(18 - CW){1'b0}}, r_cnt});
                m_b = $signed({2'b0, r_step});
            end
            S_GAIN: begin
                m_a = $signed({2'b0, r_range});
                m_b = 18'sd19899;
            end
            S_SQX: begin
                m_a = r_bx;
                m_b = r_bx;
            end
            S_SQY: begin
                m_a = r_by;
                m_b = r_by;
            end
            S_FREE: begin
                m_a = $signed({1'b0, free_mm});
                m_b = 18'sd1000;
            end
            S_ANGM: begin
                m_a = $signed({3'b0, r_limit});
                m_b = $signed({1'b0, ang_abs});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // Requests to the shared units
    always_comb begin
        cord_start   = (r_state == S_CORD_GO);
        du_req.start = (r_state == S_ROOT_GO) || (r_state == S_DIV_GO) ||
                       (r_state == S_CDIV_GO);
        du_req.op    = (r_state == S_ROOT_GO) ? lcsl_pkg::OP_SQRT : lcsl_pkg::OP_DIV;
        du_req.a     = '0;
        du_req.b     = '0;
        if (r_state == S_ROOT_GO) begin
            du_req.a = r_best;
        end else if (r_state == S_DIV_GO) begin
            du_req.a = {4'b0, r_prod[29:0]};
            du_req.b = {1'b0, t_eff};
        end else if (r_state == S_CDIV_GO) begin
            du_req.a = {4'b0, r_prod[29:0]};
            du_req.b = lin_abs;
        end
    end

    lcsl_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_x0    (r_prod[30:0]),
        .i_phase (r_phase),
        .o_done  (cord_done),
        .o_px    (cord_px),
        .o_py    (cord_py)
    );

    lcsl_root_div u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (du_req),
        .o_sts   (du_sts),
        .o_res   (du_res)
    );

    // Sequencer, scan state and output register
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_safe_time <= 16'd5000;
            r_radius    <= 16'd200;
            r_step      <= 16'd182;
            r_offset    <= 10'd64;
            r_cnt       <= '0;
            r_best      <= '1;
            r_bestx     <= '0;
            r_besty     <= '0;
            r_nearest   <= '1;
            r_ox        <= '0;
            r_oy        <= '0;
            r_limit     <= 15'h7FFF;
            r_ovalid    <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    lcsl_pkg::REG_SAFE_TIME: r_safe_time <= i_cfg_data;
                    lcsl_pkg::REG_RADIUS:    r_radius    <= i_cfg_data;
                    lcsl_pkg::REG_STEP:      r_step      <= i_cfg_data;
                    lcsl_pkg::REG_OFFSET:    r_offset    <= i_cfg_data[9:0];
                    default:                 r_offset    <= r_offset;
                endcase
            end

            // drop a taken result unless a new one replaces it
            if (m_axis_tvalid && m_axis_tready && !load_out) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_range <= s_axis_tdata[15:0];
                        r_lin   <= s_axis_tdata[31:16];
                        r_ang   <= s_axis_tdata[47:32];
                        r_last  <= s_axis_tlast;
                        r_state <= s_axis_tuser ? S_CMD : S_ANG;
                    end
                end
                S_ANG:     r_state <= S_GAIN;
                S_GAIN: begin
                    r_phase <= {r_prod[ANGLE_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}};
                    r_state <= S_CORD_GO;
                end
                S_CORD_GO: r_state <= S_CORD;
                S_CORD: begin
                    if (cord_done) begin
                        r_bx    <= cord_px - $signed({8'b0, r_offset});
                        r_by    <= cord_py;
                        r_state <= S_SQX;
                    end
                end
                S_SQX:     r_state <= S_SQY;
                S_SQY: begin
                    r_acc   <= r_prod[33:0];
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (sq < r_best) begin
                        r_best  <= sq;
                        r_bestx <= r_bx;
                        r_besty <= r_by;
                    end
                    r_cnt   <= (r_cnt == CW'(MAX_BEAMS - 1)) ? '0 : r_cnt + 1'b1;
                    r_state <= r_last ? S_ROOT_GO : S_IDLE;
                end
                S_ROOT_GO: r_state <= S_ROOT;
                S_ROOT: begin
                    if (du_sts.done) begin
                        r_d     <= du_res[16:0];
                        r_state <= S_FREE;
                    end
                end
                S_FREE:    r_state <= S_DIV_GO;
                S_DIV_GO:  r_state <= S_DIV;
                S_DIV: begin
                    if (du_sts.done) begin
                        r_limit   <= (du_res > 30'd32767) ? 15'h7FFF : du_res[14:0];
                        r_nearest <= r_d;
                        r_ox      <= r_bestx;
                        r_oy      <= r_besty;
                        r_cnt     <= '0;
                        r_best    <= '1;
                        r_state   <= S_IDLE;
                    end
                end
                S_CMD: begin
                    r_oang <= r_ang;
                    if (clip) begin
                        if (stop) begin
                            r_olin <= '0;
                        end else if (fwd) begin
                            r_olin <= {1'b0, r_limit};
                        end else begin
                            r_olin <= 16'(16'd0 - {1'b0, r_limit});
                        end
                        r_state <= S_ANGM;
                    end else begin
                        r_olin  <= r_lin;
                        r_state <= S_OUT;
                    end
                end
                S_ANGM:    r_state <= S_CDIV_GO;
                S_CDIV_GO: r_state <= S_CDIV;
                S_CDIV: begin
                    if (du_sts.done) begin
                        r_oang  <= r_ang[15] ? 16'(16'd0 - du_res[15:0]) : du_res[15:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_ovalid <= 1'b1;
                        r_m_lin  <= r_olin;
                        r_m_ang  <= r_oang;
                        r_m_dist <= r_nearest;
                        r_state  <= S_IDLE;
                    end
                end
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'b0, r_m_dist, r_m_ang, r_m_lin};

    // Shared unit is started only when free
    a_du_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        du_req.start |-> !du_sts.busy)
        else $error("root/divide unit started while busy");

    // Unit completion lands only in a waiting state
    a_du_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        du_sts.done |-> (r_state == S_ROOT || r_state == S_DIV || r_state == S_CDIV))
        else $error("root/divide result arrived outside a wait state");

    // CORDIC completion lands only while waiting for it
    a_cord_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_done |-> r_state == S_CORD)
        else $error("CORDIC result arrived outside its wait state");

    // Commit restarts the scan
    a_commit_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && du_sts.done) |=> (r_cnt == '0 && r_best == '1))
        else $error("scan not restarted after commit");

    // A result appears only from the output step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT)
        else $error("output word raised outside the output step");

endmodule

// ===== tb/lcsl_speed_checker.sv =====
`timescale 1ns / 1ps
// Checker for the lidar collision speed limiter: watches the input, output and
// register channels, predicts every command result and compares it field by field.
module lcsl_speed_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    localparam int     BEAM_MOD  = 4096;
    localparam int     ANG_BITS  = 16;
    localparam logic [16:0] NO_DIST = 17'h1FFFF;
    localparam longint NO_SQ     = 64'h3FFFFFFFF;

    typedef struct packed {
        logic [16:0] near_mm;
        logic [15:0] ang;
        logic [15:0] lin;
    } t_cmd_result;

    longint atan_tab [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861};

    // configuration copy
    int unsigned safe_time, radius, step, offset;
    // scan and committed obstacle state
    int unsigned beam_idx;
    longint      best_sq;
    int          best_x, best_y;
    int unsigned near_dist;
    int          obs_x, obs_y;
    int unsigned limit_mm_s;

    t_cmd_result expected_results[$];

    function automatic int unsigned floor_sqrt(longint v);
        longint res, bit_v;
        res = 0;
        bit_v = 64'd1 << 34;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return 32'(res);
    endfunction

    // rotate range by angle, result in whole mm
    task automatic beam_point(input int unsigned rng, input int unsigned ang,
                              output int px, output int py);
        logic [31:0] phase;
        longint x, y, z, dx, dy, c, s;
        phase = ang << (32 - ANG_BITS);
        z = phase & 32'h3FFFFFFF;
        x = longint'(rng) * 19899;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y / (longint'(1) << i);
            dy = x / (longint'(1) << i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        px = 32'(c / 32768);
        py = 32'(s / 32768);
    endtask

    task automatic take_beam(input int unsigned rng, input logic last);
        int px, py;
        longint sq, free_mm, lim;
        int unsigned t;
        beam_point(rng, (beam_idx * step) % (1 << ANG_BITS), px, py);
        px -= offset;
        sq = longint'(px) * px + longint'(py) * py;
        if (sq < best_sq) begin
            best_sq = sq; best_x = px; best_y = py;
        end
        beam_idx = (beam_idx + 1) % BEAM_MOD;
        if (last) begin
            near_dist = floor_sqrt(best_sq);
            t = safe_time != 0 ? safe_time : 1;
            free_mm = near_dist >= radius ? near_dist - radius : radius - near_dist;
            lim = free_mm * 1000 / t;
            near_dist &= NO_DIST;
            obs_x = best_x;
            obs_y = best_y;
            limit_mm_s = lim > 32767 ? 32767 : 32'(lim);
            beam_idx = 0;
            best_sq = NO_SQ;
        end
    endtask

    function automatic t_cmd_result limit_command(input logic signed [15:0] lin,
                                                  input logic signed [15:0] ang);
        t_cmd_result r;
        longint lim, mag, absy, l, a;
        int out_lin, out_ang;
        logic stop;
        lim = limit_mm_s;
        l = lin;
        a = ang;
        out_lin = lin;
        out_ang = ang;
        mag = l < 0 ? -l : l;
        absy = obs_y < 0 ? -obs_y : obs_y;
        if (absy < radius && mag > lim) begin
            stop = near_dist < radius;
            if (l >= 0) begin
                if (obs_x >= 0) begin
                    out_lin = stop ? 0 : 32'(lim);
                    if (l != 0) out_ang = 32'((lim * a) / l);
                end
            end else if (obs_x <= 0) begin
                out_lin = stop ? 0 : 32'(-lim);
                out_ang = 32'(-(lim * a) / l);
            end
        end
        r.lin = out_lin[15:0];
        r.ang = out_ang[15:0];
        r.near_mm = near_dist[16:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cmd_result got, want;
        if (!i_rst_n) begin
            safe_time <= 5000; radius <= 200; step <= 182; offset <= 64;
            beam_idx = 0; best_sq = NO_SQ; best_x = 0; best_y = 0;
            near_dist = NO_DIST; obs_x = 0; obs_y = 0; limit_mm_s = 32767;
            expected_results.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
            o_pending <= 0;
        end else begin
            // register writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    lcsl_pkg::REG_SAFE_TIME: safe_time <= i_cfg_data;
                    lcsl_pkg::REG_RADIUS:    radius <= i_cfg_data;
                    lcsl_pkg::REG_STEP:      step <= i_cfg_data;
                    lcsl_pkg::REG_OFFSET:    offset <= i_cfg_data[9:0];
                endcase
            end
            // input words
            if (s_axis_tvalid && s_axis_tready) begin
                if (!s_axis_tuser)
                    take_beam(s_axis_tdata[15:0], s_axis_tlast);
                else
                    expected_results.push_back(
                        limit_command(s_axis_tdata[31:16], s_axis_tdata[47:32]));
            end
            // output words
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[48:0];
                o_result_count <= o_result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result lin=%0d ang=%0d dist=%0d", $time,
                             $signed(got.lin), $signed(got.ang), got.near_mm);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.lin !== want.lin || got.ang !== want.ang
                        || got.near_mm !== want.near_mm) begin
                        $display("%0t: mismatch expected lin=%0d ang=%0d dist=%0d, got lin=%0d ang=%0d dist=%0d",
                                 $time, $signed(want.lin), $signed(want.ang), want.near_mm,
                                 $signed(got.lin), $signed(got.ang), got.near_mm);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end
endmodule

// ===== tb/lidar_collision_speed_limiter_top_test.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the lidar collision speed limiter.
// Depends on lidar_collision_speed_limiter_top, lcsl_speed_checker and lcsl_pkg.
module lidar_collision_speed_limiter_top_test;
    localparam logic KIND_BEAM = 1'b0, KIND_CMD = 1'b1;
    localparam int   STALL_LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_data = '0;
    int          fail_count, pending, result_count;
    int          idle_cycles;
    int          sent_words;

    always #6 i_clk = ~i_clk;

    lidar_collision_speed_limiter_top DUT (.*);

    lcsl_speed_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_valid,
        .o_cfg_ready, .i_cfg_addr, .i_cfg_data, .o_fail_count(fail_count),
        .o_pending(pending), .o_result_count(result_count)
    );

    // receiver: random stall before each word, some stretches with none
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap != 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk iff m_axis_tvalid);
        end
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // without random_gap, valid stays high into the next word
    task automatic send_word(input logic kind, input logic [15:0] rng,
                             input logic last, input logic [15:0] lin,
                             input logic [15:0] ang, input bit random_gap);
        int gap;
        gap = random_gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16)) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {ang, lin, rng};
        s_axis_tvalid <= 1;
        @(posedge i_clk iff s_axis_tready);
        sent_words++;
    endtask

    task automatic send_beam(input logic [15:0] rng, input logic last);
        send_word(KIND_BEAM, rng, last, 16'($urandom), 16'($urandom), 1);
    endtask

    task automatic send_cmd(input logic [15:0] lin, input logic [15:0] ang);
        send_word(KIND_CMD, 16'($urandom), 1'($urandom_range(0, 1)), lin, ang, 1);
    endtask

    // let the block drain before touching registers
    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // one scan with mostly far beams and an occasional near one
    task automatic random_scan();
        int n;
        logic [15:0] r;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: r = 16'($urandom_range(0, 400));
                1: r = 16'($urandom_range(0, 3000));
                2: r = 16'($urandom);
                default: r = 16'($urandom_range(200, 1500));
            endcase
            send_beam(r, i == n - 1);
        end
    endtask

    task automatic random_cmd();
        logic [15:0] lin;
        case ($urandom_range(0, 3))
            0: lin = 16'($urandom_range(0, 2000));
            1: lin = 16'(-$urandom_range(0, 2000));
            default: lin = 16'($urandom);
        endcase
        send_cmd(lin, 16'($urandom));
    endtask

    task automatic random_phase(input int words);
        int start_cnt;
        start_cnt = sent_words;
        while (sent_words - start_cnt < words) begin
            case ($urandom_range(0, 5))
                0, 1: random_scan();
                2: send_beam(16'($urandom), 0);
                default: random_cmd();
            endcase
        end
        drain();
    endtask

    initial begin
        sent_words = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // no scan committed yet: limit is open
        send_cmd(16'sd32767, 16'sd1000);
        send_cmd(-16'sd32768, -16'sd32768);
        send_cmd(16'sd0, 16'sd0);
        // obstacle right ahead, close: stop, then reverse passes
        send_beam(16'd150, 0);
        send_beam(16'd150, 1);
        send_cmd(16'sd500, 16'sd300);
        send_cmd(-16'sd500, 16'sd300);
        send_cmd(16'sd0, -16'sd700);
        // far straight-ahead scan with tied ranges, then clipping
        send_beam(16'd2000, 0);
        send_beam(16'd2000, 0);
        send_beam(16'd65535, 1);
        send_cmd(16'sd2000, -16'sd1200);
        send_cmd(16'sd10, 16'sd5);
        // zero range gives a point behind the sensor
        send_beam(16'd0, 1);
        send_cmd(-16'sd3000, 16'sd2000);
        send_cmd(16'sd3000, 16'sd2000);
        drain();

        // extremes: zero safe time, zero radius, half-turn step, max offset
        write_reg(lcsl_pkg::REG_SAFE_TIME, 16'd0);
        write_reg(lcsl_pkg::REG_RADIUS, 16'd0);
        write_reg(lcsl_pkg::REG_STEP, 16'd32768);
        write_reg(lcsl_pkg::REG_OFFSET, 16'd1023);
        send_beam(16'd65535, 0);
        send_beam(16'd1000, 1);
        send_cmd(-16'sd32768, 16'sd32767);
        random_phase(150);

        write_reg(lcsl_pkg::REG_SAFE_TIME, 16'd65535);
        write_reg(lcsl_pkg::REG_RADIUS, 16'd65535);
        write_reg(lcsl_pkg::REG_STEP, 16'd65535);
        write_reg(lcsl_pkg::REG_OFFSET, 16'd0);
        random_phase(150);

        // one long back-to-back scan with a fine step
        write_reg(lcsl_pkg::REG_SAFE_TIME, 16'd1000);
        write_reg(lcsl_pkg::REG_RADIUS, 16'd400);
        write_reg(lcsl_pkg::REG_STEP, 16'd1);
        for (int i = 0; i < 300; i++)
            send_word(KIND_BEAM, (i % 97 == 0) ? 16'd300 : 16'd5000, i == 299,
                      16'($urandom), 16'($urandom), 0);
        send_cmd(16'sd3000, 16'sd100);
        drain();

        for (int p = 0; p < 4; p++) begin
            write_reg(lcsl_pkg::REG_SAFE_TIME, 16'($urandom_range(1, 3000)));
            write_reg(lcsl_pkg::REG_RADIUS, 16'($urandom_range(0, 1500)));
            write_reg(lcsl_pkg::REG_STEP, 16'($urandom));
            write_reg(lcsl_pkg::REG_OFFSET, 16'($urandom_range(0, 1023)));
            random_phase(150);
        end

        repeat (200) @(posedge i_clk);
        $display("Run sent %0d words across beams, scans and commands under eight register",
                 sent_words);
        $display("settings, including a 300-beam scan; %0d results compared.", result_count);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== lidar_collision_speed_limiter_top.f =====
sv/lcsl_pkg.sv
sv/lcsl_root_div.sv
sv/lcsl_cordic.sv
sv/lidar_collision_speed_limiter_top.sv
tb/lcsl_speed_checker.sv
tb/lidar_collision_speed_limiter_top_test.sv
